/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Needs nothing else; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed: label");

`endif

/* sv/hpte_pkg.sv */
// Package of the hashed page table entry manager: codes, field positions and state type.
// Used by the top level, hpte_group_search, the checker and the bench; depends on nothing.
package hpte_pkg;

	// Operation carried in the input tuser.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_INSERTED = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_REMOVED  = 2'd2,
		STATUS_NOMATCH  = 2'd3
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TABLE_BASE = 2'd0;
	localparam logic [1:0] CFG_HASH_MASK  = 2'd1;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register reset values.
	localparam logic [15:0] TABLE_BASE_RESET = 16'h0000;
	localparam logic [3:0]  HASH_MASK_RESET  = 4'hF;

	// Entry word bits.
	localparam int unsigned VALID_BIT   = 31;
	localparam int unsigned CHANGED_BIT = 7;
	localparam int unsigned ENTRY_W     = 64;

	// Hash geometry.
	localparam int unsigned HASH_W     = 19;
	localparam int unsigned HASH_LOW_W = 10;
	localparam int unsigned HASH_HI_W  = HASH_W - HASH_LOW_W;

	// Stream word widths.
	localparam int unsigned IN_DATA_W  = 120;
	localparam int unsigned OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

/* sv/hashed_page_table_entry_manager.sv */
// Hashed page table entry manager: top level with group memory, control and result register.
// Depends on hpte_pkg, hpte_ram and hpte_group_search.
// A word taken in ST_IDLE has its row read; its result loads as ST_UPDATE ends, and a hit
// writes the row back. ST_UPDATE waits while a result word is stalled; no word is taken
// outside ST_IDLE. Reset: arst_n clears control; config is taken; a clearing pass zeroes
// all 2**(10+HASH_MASK_BITS) rows (16384 by default), one row a cycle, with s_tready low.
module hashed_page_table_entry_manager import hpte_pkg::*; #(
	parameter int unsigned SLOTS_PER_GROUP = 8,
	parameter int unsigned HASH_MASK_BITS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata: effective_address[31:0], segment_id[55:32], entry_word0[87:56],
	// entry_word1[119:88]
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// s_tuser: kind[0]
	input  logic                   s_tuser,
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: status[1:0], slot[4:2], group_address[36:5], invalidate_request[37],
	// invalidate_address[69:38], zero[71:70]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned GROUP_W   = HASH_LOW_W + HASH_MASK_BITS;
	localparam int unsigned GROUPS    = 1 << GROUP_W;
	localparam int unsigned ROW_W     = SLOTS_PER_GROUP * ENTRY_W;
	localparam int unsigned SLOT_W    = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
	localparam logic [HASH_HI_W-1:0] HIGH_MASK = HASH_HI_W'((1 << HASH_MASK_BITS) - 1);

	state_t state_q, state_d;

	logic [15:0] table_base_q;
	logic [3:0]  hash_mask_q;

	logic [GROUP_W-1:0] clr_q;

	// Item registers.
	logic               kind_q;
	logic [31:0]        ea_q;
	logic [31:0]        w0_q;
	logic [31:0]        w1_q;
	logic [31:0]        gaddr_q;
	logic [GROUP_W-1:0] group_q;

	// Result register.
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// Input fields.
	logic [31:0] in_ea;
	logic [23:0] in_sid;
	logic [31:0] in_w0;
	logic [31:0] in_w1;

	// Hash and group selection.
	logic [HASH_W-1:0]     hash;
	logic [HASH_HI_W-1:0]  hash_hi;
	logic [HASH_LOW_W-1:0] hash_lo;
	logic [HASH_W-1:0]     group_full;
	logic [31:0]           gaddr;

	// Memory ports.
	logic               mem_we;
	logic [GROUP_W-1:0] mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;
	logic               mem_re;
	logic [ROW_W-1:0]   mem_rdata;

	// Search results.
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;
	logic [ROW_W-1:0]  row_new;

	logic in_accept;
	logic out_free;
	logic load_out;

	assign in_ea  = s_tdata[31:0];
	assign in_sid = s_tdata[55:32];
	assign in_w0  = s_tdata[87:56];
	assign in_w1  = s_tdata[119:88];

	// Primary hash and group index; only masked high hash bits take part.
	assign hash       = in_sid[HASH_W-1:0] ^ in_ea[12 +: HASH_W];
	assign hash_hi    = hash[HASH_W-1:HASH_LOW_W] & {{(HASH_HI_W-4){1'b0}}, hash_mask_q}
		& HIGH_MASK;
	assign hash_lo    = hash[HASH_LOW_W-1:0];
	assign group_full = {hash_hi, hash_lo};
	assign gaddr      = {table_base_q, 16'h0000} | {7'b0, hash_hi, 16'h0000}
		| {16'h0000, hash_lo, 6'b000000};

	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= TABLE_BASE_RESET;
			hash_mask_q  <= HASH_MASK_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TABLE_BASE: table_base_q <= cfg_data;
				CFG_HASH_MASK:  hash_mask_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// State register and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + GROUP_W'(1);
			end
		end
	end

	// Next state, handshake and memory control.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = group_q;
		mem_wdata = row_new;
		mem_re    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == GROUP_W'(GROUPS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_re   = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// Row data is held until the result register can take the result.
				if (out_free) begin
					mem_we   = hit;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	hpte_ram #(
		.WIDTH (ROW_W),
		.DEPTH (GROUPS)
	) u_group_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (group_full[GROUP_W-1:0]),
		.rdata (mem_rdata)
	);

	hpte_group_search #(
		.SLOTS_PER_GROUP (SLOTS_PER_GROUP)
	) u_search (
		.kind     (kind_q),
		.word0    (w0_q),
		.word1    (w1_q),
		.row      (mem_rdata),
		.hit      (hit),
		.hit_slot (hit_slot),
		.row_new  (row_new)
	);

	// Item capture at acceptance.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q  <= s_tuser;
			ea_q    <= in_ea;
			w0_q    <= in_w0;
			w1_q    <= in_w1;
			gaddr_q <= gaddr;
			group_q <= group_full[GROUP_W-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		status_t     status;
		logic [2:0]  slot;
		logic [31:0] inv_addr;
		if (load_out) begin
			if (kind_q == KIND_REMOVE) begin
				status   = hit ? STATUS_REMOVED : STATUS_NOMATCH;
				inv_addr = ea_q;
			end else begin
				status   = hit ? STATUS_INSERTED : STATUS_FULL;
				inv_addr = 32'h0000_0000;
			end
			slot = hit ? 3'(hit_slot) : 3'b000;
			m_tdata_q <= {2'b00, inv_addr, kind_q, gaddr_q, slot, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sv/hpte_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module hpte_ram #(
	parameter int unsigned WIDTH = 512,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/hpte_group_search.sv */
// Slot search and update of one entry group: first free slot on insert, first match on remove.
// Depends on hpte_pkg.
module hpte_group_search import hpte_pkg::*; #(
	parameter int unsigned SLOTS_PER_GROUP = 8
) (
	input  logic                                  kind,
	input  logic [31:0]                           word0,
	input  logic [31:0]                           word1,
	input  logic [SLOTS_PER_GROUP*ENTRY_W-1:0]    row,
	output logic                                  hit,
	output logic [((SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1)-1:0] hit_slot,
	output logic [SLOTS_PER_GROUP*ENTRY_W-1:0]    row_new
);

	localparam int unsigned SLOT_W = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;

	logic [SLOTS_PER_GROUP-1:0] cand;

	// Per-slot test, all slots in parallel.
	always_comb begin
		logic [31:0] s0;
		logic [31:0] s1;
		logic [31:0] s1_masked;
		for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
			s0 = row[i*ENTRY_W+32 +: 32];
			s1 = row[i*ENTRY_W +: 32];
			s1_masked = s1;
			s1_masked[CHANGED_BIT] = 1'b0;
			if (kind == KIND_REMOVE) begin
				cand[i] = s0[VALID_BIT] && (s0 == word0) && (s1_masked == word1);
			end else begin
				cand[i] = !s0[VALID_BIT];
			end
		end
	end

	// Lowest candidate wins; insert writes the new entry there, remove clears valid and bits 1:0.
	always_comb begin
		logic        found;
		logic [31:0] s0;
		logic [31:0] s1;
		found = 1'b0;
		hit_slot = '0;
		row_new = row;
		for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
			s0 = row[i*ENTRY_W+32 +: 32];
			s1 = row[i*ENTRY_W +: 32];
			if (cand[i] && !found) begin
				found = 1'b1;
				hit_slot = SLOT_W'(i);
				if (kind == KIND_REMOVE) begin
					s0[VALID_BIT] = 1'b0;
					s1[1:0] = 2'b00;
					row_new[i*ENTRY_W +: ENTRY_W] = {s0, s1};
				end else begin
					row_new[i*ENTRY_W +: ENTRY_W] = {word0, word1};
				end
			end
		end
		hit = found;
	end

endmodule

/* sv/hpte_checker.sv */
// Port-level checker for the hashed page table entry manager, bound to the top level.
// Depends on hpte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hpte_checker import hpte_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [1:0] status;
	logic [2:0] slot;
	logic       inv_req;

	assign status  = m_tdata[1:0];
	assign slot    = m_tdata[4:2];
	assign inv_req = m_tdata[37];

	// A stalled result word holds its value.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One item at a time: no word is taken in the cycle after one was taken.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// Only removals request an invalidate, and each removal does.
	`ASSERT_IMPLIES(a_inv_kind, clk, arst_n, m_tvalid,
		inv_req == ((status == STATUS_REMOVED) || (status == STATUS_NOMATCH)))

	// A result that touched no slot reports slot zero.
	`ASSERT_IMPLIES(a_slot_zero, clk, arst_n,
		m_tvalid && ((status == STATUS_FULL) || (status == STATUS_NOMATCH)), slot == 3'b000)

endmodule

bind hashed_page_table_entry_manager hpte_checker u_hpte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* bench/pte_outcome_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the hashed page table entry manager bench: shadow entry table and result checks.
// Depends on hpte_pkg for codes, field widths and register indexes.
package pte_outcome_pkg;
	import hpte_pkg::*;

	// Geometry of the block as instantiated by the bench (default parameters).
	localparam int unsigned SLOTS       = 8;
	localparam int unsigned MASK_BITS   = 4;
	localparam int unsigned GROUPS      = 1 << (HASH_LOW_W + MASK_BITS);
	localparam int unsigned ENTRY_COUNT = SLOTS * GROUPS;

	// One result word, unpacked.
	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [31:0] group_address;
		logic        invalidate_request;
		logic [31:0] invalidate_address;
	} pte_outcome_t;

	class pte_outcome_checker;
		// Entries never written read as zero, which matches the cleared table.
		logic [ENTRY_W-1:0] entry_shadow [int unsigned];
		logic [15:0]        table_base;
		logic [3:0]         hash_mask;
		pte_outcome_t       pending_outcomes [$];
		int unsigned        errors;

		function new();
			table_base = TABLE_BASE_RESET;
			hash_mask  = HASH_MASK_RESET;
			errors     = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			if (index == CFG_TABLE_BASE) begin
				table_base = value;
			end else if (index == CFG_HASH_MASK) begin
				hash_mask = value[3:0];
			end
		endfunction

		function int unsigned pending();
			return pending_outcomes.size();
		endfunction

		// Apply one accepted request word to the shadow table and queue its outcome.
		function void note_request(logic kind, logic [31:0] ea, logic [23:0] vsid,
				logic [31:0] w0, logic [31:0] w1);
			logic [HASH_W-1:0]    hash;
			logic [HASH_HI_W-1:0] high;
			logic [HASH_LOW_W-1:0] low;
			logic [ENTRY_W-1:0]   entry;
			logic [31:0]          s0;
			logic [31:0]          s1;
			int unsigned          first;
			int unsigned          idx;
			int unsigned          s;
			pte_outcome_t         res;

			hash  = vsid[HASH_W-1:0] ^ ea[12 +: HASH_W];
			// The register is exactly MASK_BITS wide, so all of it takes effect.
			high  = hash[HASH_W-1:HASH_LOW_W] & HASH_HI_W'(hash_mask);
			low   = hash[HASH_LOW_W-1:0];
			first = {high, low} * SLOTS;

			res.status             = (kind == KIND_INSERT) ? STATUS_FULL : STATUS_NOMATCH;
			res.slot               = '0;
			res.group_address      = {table_base, 16'h0000} | (32'(high) << 16) | (32'(low) << 6);
			res.invalidate_request = (kind == KIND_REMOVE);
			res.invalidate_address = (kind == KIND_REMOVE) ? ea : 32'h0;

			for (s = 0; s < SLOTS; s++) begin
				idx   = (first + s) % ENTRY_COUNT;
				entry = entry_shadow.exists(idx) ? entry_shadow[idx] : '0;
				s0    = entry[63:32];
				s1    = entry[31:0];
				if (kind == KIND_INSERT) begin
					// First free slot takes the entry as given, valid or not.
					if (!s0[VALID_BIT]) begin
						entry_shadow[idx] = {w0, w1};
						res.status        = STATUS_INSERTED;
						res.slot          = 3'(s);
						break;
					end
				end else begin
					// The changed bit of the stored entry is ignored in the match.
					if (s0[VALID_BIT] && s0 == w0 && (s1 & ~(32'd1 << CHANGED_BIT)) == w1) begin
						entry_shadow[idx] = {s0 & ~(32'd1 << VALID_BIT), s1 & ~32'h3};
						res.status        = STATUS_REMOVED;
						res.slot          = 3'(s);
						break;
					end
				end
			end
			pending_outcomes.push_back(res);
		endfunction

		function void report_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result word with the oldest expected outcome.
		function void check_outcome(logic [OUT_DATA_W-1:0] word);
			pte_outcome_t want;

			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result word 0x%0h", $time, word);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			report_field("status", 32'(want.status), 32'(word[1:0]));
			report_field("slot", 32'(want.slot), 32'(word[4:2]));
			report_field("group_address", want.group_address, word[36:5]);
			report_field("invalidate_request", 32'(want.invalidate_request), 32'(word[37]));
			report_field("invalidate_address", want.invalidate_address, word[69:38]);
			report_field("padding", 32'h0, 32'(word[71:70]));
		endfunction
	endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the bench for the hashed page table entry manager: clock, reset, drivers and monitor.
// Depends on hpte_pkg, pte_outcome_pkg and the block's RTL.
module tb_top;
	import hpte_pkg::*;
	import pte_outcome_pkg::*;

	localparam int unsigned QUIET_LIMIT = 60000;
	localparam int unsigned LONG_HOLD   = 200;
	localparam int unsigned POOL_SIZE   = 6;
	localparam int unsigned LIVE_MAX    = 48;

	typedef struct {
		logic [HASH_W-1:0] hash;
		logic [31:0]       ea;
		logic [23:0]       vsid;
		logic [31:0]       w0;
		logic [31:0]       w1;
	} pte_record_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pte_outcome_checker sb = new();

	// Stimulus state: a few hot hashes so groups fill up, and entries known to be stored.
	logic [HASH_W-1:0] hot_hash [POOL_SIZE];
	pte_record_t       live [$];
	bit                tx_steady;
	bit                rx_steady;
	bit                rx_hold_request;
	int unsigned       quiet_cycles;

	hashed_page_table_entry_manager dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Offer one request word, after a random gap unless tx_steady is set, and wait until it is taken.
	task automatic send_item(logic kind, logic [31:0] ea, logic [23:0] vsid,
			logic [31:0] w0, logic [31:0] w1);
		int unsigned gap;

		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {w1, w0, vsid, ea};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(kind, ea, vsid, w0, w1);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last register.
	task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(index, value);
	endtask

	task automatic configure(logic [15:0] base, logic [3:0] mask);
		write_register(CFG_TABLE_BASE, base);
		write_register(CFG_HASH_MASK, {12'h000, mask});
		cfg_valid <= 1'b0;
	endtask

	// Stop offering words and let every outstanding result drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Half of the hot hashes share their low bits, so they alias when the mask is narrow.
	task automatic refresh_pool();
		logic [HASH_LOW_W-1:0] common_low;

		common_low = HASH_LOW_W'($urandom);
		for (int i = 0; i < POOL_SIZE; i++) begin
			hot_hash[i] = {HASH_HI_W'($urandom),
				(i < POOL_SIZE / 2) ? common_low : HASH_LOW_W'($urandom)};
		end
		live.delete();
	endtask

	// Random address and segment id whose primary hash is the given one.
	function automatic void aim_at(logic [HASH_W-1:0] h, output logic [31:0] ea,
			output logic [23:0] vsid);
		vsid = 24'($urandom);
		ea   = $urandom;
		ea[12 +: HASH_W] = h ^ vsid[HASH_W-1:0];
	endfunction

	task automatic run_directed();
		pte_record_t fill [SLOTS];
		logic [HASH_W-1:0] h;
		logic [31:0] ea;
		logic [23:0] vsid;

		// Fill one group completely, then one more insert finds it full.
		h = 19'h2A5C3;
		for (int i = 0; i < SLOTS; i++) begin
			aim_at(h, fill[i].ea, fill[i].vsid);
			fill[i].w0 = 32'h8000_0000 | i;
			fill[i].w1 = 32'h0000_0083 | (i << 12);
			send_item(KIND_INSERT, fill[i].ea, fill[i].vsid, fill[i].w0, fill[i].w1);
		end
		aim_at(h, ea, vsid);
		send_item(KIND_INSERT, ea, vsid, 32'hC000_0000, 32'h1);
		// Remove ignores the stored changed bit; a second remove finds nothing.
		send_item(KIND_REMOVE, ea, vsid, fill[3].w0, fill[3].w1 & ~32'h80);
		send_item(KIND_REMOVE, fill[3].ea, fill[3].vsid, fill[3].w0, fill[3].w1 & ~32'h80);
		// A remove that asks for the changed bit never matches.
		send_item(KIND_REMOVE, fill[4].ea, fill[4].vsid, fill[4].w0, fill[4].w1);
		aim_at(h, ea, vsid);
		send_item(KIND_INSERT, ea, vsid, 32'hFFFF_FFFF, 32'h0);
		// An entry stored without its valid bit leaves the slot free.
		send_item(KIND_INSERT, 32'h0, 24'h0, 32'h0, 32'h0);
		send_item(KIND_INSERT, 32'h0, 24'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_REMOVE, 32'h0, 24'h0, 32'hFFFF_FFFF, 32'hFFFF_FF7F);
		send_item(KIND_REMOVE, 32'h0, 24'h0, 32'h0, 32'h0);
		send_item(KIND_REMOVE, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// All hash bits set: the highest group under the full mask.
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 24'h0, 32'h8765_4321, 32'hFFFF_FFFF);
	endtask

	// One random word: mostly inserts and matching removes on the hot groups.
	task automatic random_item();
		pte_record_t r;
		logic [31:0] ea;
		logic [23:0] vsid;
		logic [31:0] w0;
		logic [31:0] w1;
		int unsigned roll;
		int unsigned k;

		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			r.hash = hot_hash[$urandom_range(0, POOL_SIZE - 1)];
			aim_at(r.hash, r.ea, r.vsid);
			r.w0     = $urandom;
			r.w0[31] = ($urandom_range(0, 9) != 0);
			r.w1     = $urandom;
			send_item(KIND_INSERT, r.ea, r.vsid, r.w0, r.w1);
			if (r.w0[31]) begin
				live.push_back(r);
				if (live.size() > LIVE_MAX) void'(live.pop_front());
			end
		end else if (roll < 80 && live.size() > 0) begin
			k = $urandom_range(0, live.size() - 1);
			r = live[k];
			live.delete(k);
			if ($urandom_range(0, 1) == 1) begin
				aim_at(r.hash, ea, vsid);
			end else begin
				ea   = r.ea;
				vsid = r.vsid;
			end
			w0 = r.w0;
			w1 = r.w1 & ~32'h80;
			// A few removes are spoiled so that they cannot match.
			case ($urandom_range(0, 19))
				0, 1: w1[CHANGED_BIT] = 1'b1;
				2: w0 = w0 ^ (32'd1 << $urandom_range(0, 31));
				3: w1 = w1 ^ (32'd1 << $urandom_range(8, 31));
				default: ;
			endcase
			send_item(KIND_REMOVE, ea, vsid, w0, w1);
		end else if (roll < 90) begin
			aim_at(hot_hash[$urandom_range(0, POOL_SIZE - 1)], ea, vsid);
			send_item(KIND_REMOVE, ea, vsid, $urandom, $urandom);
		end else begin
			send_item($urandom_range(0, 1) ? KIND_REMOVE : KIND_INSERT, $urandom,
				24'($urandom), $urandom, $urandom);
		end
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) random_item();
	endtask

	// Main sequence: reset, then phases with different register settings.
	initial begin
		arst_n          <= 1'b0;
		s_tvalid        <= 1'b0;
		s_tuser         <= KIND_INSERT;
		s_tdata         <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= CFG_TABLE_BASE;
		cfg_data        <= '0;
		tx_steady       = 1'b0;
		rx_steady       = 1'b0;
		rx_hold_request = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'h0000, 4'hF);
		refresh_pool();
		run_directed();
		run_random(260);

		settle();
		configure(16'hFFFF, 4'h0);
		refresh_pool();
		run_random(260);

		// The receiver holds off for a long stretch so the block backs up.
		settle();
		configure(16'($urandom), 4'($urandom_range(1, 14)));
		refresh_pool();
		rx_hold_request = 1'b1;
		run_random(260);

		// A stretch with no idling on either side.
		settle();
		configure(16'h8001, 4'h8);
		refresh_pool();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_random(120);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_random(140);

		settle();
		configure(16'($urandom), 4'hF);
		refresh_pool();
		run_random(260);

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Result side: a random stall before each word, or one long hold when asked.
	initial begin
		int unsigned stall;

		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_request) begin
				stall           = LONG_HOLD;
				rx_hold_request = 1'b0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Check every result word taken at this edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_outcome(m_tdata);
		end
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* sim.f */
+incdir+sv
sv/hpte_pkg.sv
sv/hpte_ram.sv
sv/hpte_group_search.sv
sv/hashed_page_table_entry_manager.sv
sv/hpte_checker.sv
bench/pte_outcome_pkg.sv
bench/tb_top.sv
